// ===== design/lmft_pkg.sv =====
// ----------------------------------------------------------------------------
// lmft_pkg: shared types and constants of the LIN master frame transmitter
// Request classes, queue entry layout, bus symbol codes and the PID function.
// ----------------------------------------------------------------------------
package lmft_pkg;

  // Frame limits and fixed bytes
  localparam int unsigned MAX_DATA_BYTES = 8;
  localparam int unsigned LEN_W          = 4;
  localparam int unsigned QUEUE_DEPTH    = 2;
  localparam logic [7:0]  SYNC_BYTE      = 8'h55;
  localparam logic [7:0]  WAKE_BYTE      = 8'hF0;
  localparam logic [5:0]  SLEEP_ID       = 6'h3C;
  localparam logic [63:0] SLEEP_DATA     = 64'hFFFF_FFFF_FFFF_FF00;

  // Bus symbol kinds on the output stream
  localparam logic [1:0] KIND_BREAK  = 2'd0;
  localparam logic [1:0] KIND_BYTE   = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  // Request commands
  localparam logic [1:0] CMD_FRAME = 2'd0;
  localparam logic [1:0] CMD_SLEEP = 2'd1;
  localparam logic [1:0] CMD_WAKE  = 2'd2;

  // Classified job kinds
  typedef enum logic [1:0] {
    JOB_REJECT,
    JOB_WAKE,
    JOB_HEADER,
    JOB_FRAME
  } job_kind_t;

  // Symbol sequencer states
  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SYNC,
    ST_PID,
    ST_DATA,
    ST_CSUM
  } back_state_t;

  // One queued job
  typedef struct packed {
    job_kind_t        kind;
    logic [7:0]       pid;
    logic             enhanced;
    logic [LEN_W-1:0] len;
    logic [63:0]      data;
    logic             status;
  } job_t;

  // Queue handshake between front and back
  typedef struct packed {
    logic push;
    logic pop;
    logic full;
    logic empty;
  } queue_ctl_t;

  // Protected identifier: id, P0 in bit 6, inverted P1 in bit 7
  function automatic logic [7:0] lin_pid(input logic [5:0] id);
    logic p0;
    logic p1;
    p0 = id[0] ^ id[1] ^ id[2] ^ id[4];
    p1 = ~(id[1] ^ id[3] ^ id[4] ^ id[5]);
    return {p1, p0, id};
  endfunction

endpackage

// ===== design/lmft_front.sv =====
// ----------------------------------------------------------------------------
// lmft_front: request intake and classification
// Holds the enable register and the driver status, checks each request and
// builds the job that the sequencer plays out.
// ----------------------------------------------------------------------------
module lmft_front import lmft_pkg::*; (
  input  logic             clk,
  input  logic             rst,
  input  logic             cfg_wr_en,
  input  logic             cfg_wr_data,
  input  logic             req_valid,
  output logic             req_ready,
  input  logic [1:0]       cmd,
  input  logic [5:0]       frame_id,
  input  logic             enhanced_checksum,
  input  logic             master_response,
  input  logic [LEN_W-1:0] data_length,
  input  logic [63:0]      data_bytes,
  input  logic             queue_full,
  output logic             queue_push,
  output job_t             job
);

  logic driver_enabled;
  logic driver_status;
  logic driver_status_next;
  logic bad_len;

  assign req_ready  = ~queue_full;
  assign queue_push = req_valid & req_ready;
  assign bad_len    = (data_length == '0) ||
                      (data_length > LEN_W'(MAX_DATA_BYTES));

  // Classify the request and work out the status after it
  always_comb begin
    job.kind     = JOB_REJECT;
    job.pid      = lin_pid(frame_id);
    job.enhanced = enhanced_checksum;
    job.len      = data_length;
    job.data     = data_bytes;
    case (cmd)
      CMD_FRAME: begin
        if (!bad_len) begin
          job.kind = master_response ? JOB_FRAME : JOB_HEADER;
        end
      end
      CMD_SLEEP: begin
        job.pid      = lin_pid(SLEEP_ID);
        job.enhanced = 1'b0;
        job.len      = LEN_W'(8);
        job.data     = SLEEP_DATA;
        if (MAX_DATA_BYTES >= 8) begin
          job.kind = JOB_FRAME;
        end
      end
      CMD_WAKE: begin
        job.kind = JOB_WAKE;
      end
      default: begin
        job.kind = JOB_REJECT;
      end
    endcase
    if (!driver_enabled) begin
      job.kind = JOB_REJECT;
    end
    // Status after this request
    case (job.kind)
      JOB_HEADER: driver_status_next = 1'b0;
      JOB_FRAME:  driver_status_next = 1'b1;
      default:    driver_status_next = driver_status;
    endcase
    job.status = driver_status_next;
  end

  // Enable and status registers
  always_ff @(posedge clk) begin
    if (rst) begin
      driver_enabled <= 1'b0;
      driver_status  <= 1'b0;
    end else begin
      if (cfg_wr_en) begin
        driver_enabled <= cfg_wr_data;
      end
      if (queue_push) begin
        driver_status <= driver_status_next;
      end
    end
  end

endmodule

// ===== design/lmft_queue.sv =====
// ----------------------------------------------------------------------------
// lmft_queue: job queue
// Short FIFO between intake and sequencer so that each side stalls alone.
// ----------------------------------------------------------------------------
module lmft_queue import lmft_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  queue_ctl_t ctl_in,
  output queue_ctl_t ctl_out,
  input  job_t       wr_job,
  output job_t       rd_job
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);
  localparam int unsigned CNT_W = $clog2(QUEUE_DEPTH + 1);

  job_t             entries [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [CNT_W-1:0] count;
  logic             do_push;
  logic             do_pop;

  assign ctl_out.push  = do_push;
  assign ctl_out.pop   = do_pop;
  assign ctl_out.full  = (count == CNT_W'(QUEUE_DEPTH));
  assign ctl_out.empty = (count == '0);
  assign do_push       = ctl_in.push & ~ctl_out.full;
  assign do_pop        = ctl_in.pop & ~ctl_out.empty;
  assign rd_job        = entries[rd_ptr];

  // Storage
  always_ff @(posedge clk) begin
    if (do_push) begin
      entries[wr_ptr] <= wr_job;
    end
  end

  // Pointers and fill count
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= (wr_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= (rd_ptr == PTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (do_push && !do_pop) begin
        count <= count + 1'b1;
      end else if (do_pop && !do_push) begin
        count <= count - 1'b1;
      end
    end
  end

endmodule

// ===== design/lmft_back.sv =====
// ----------------------------------------------------------------------------
// lmft_back: bus symbol sequencer
// Plays a job as a reject, a wakeup, or break, sync, PID, data and checksum
// symbols, one per unstalled cycle into the output register, summing the data.
// ----------------------------------------------------------------------------
module lmft_back import lmft_pkg::*; (
  input  logic       clk,
  input  logic       rst,
  input  logic       queue_empty,
  output logic       queue_pop,
  input  job_t       head,
  output logic       out_valid,
  input  logic       out_ready,
  output logic [1:0] out_kind,
  output logic [7:0] out_byte,
  output logic       out_last,
  output logic       out_status
);

  back_state_t state;
  back_state_t state_next;
  job_t        job;
  logic [2:0]  idx;
  logic [7:0]  sum;
  logic [8:0]  sum_wide;
  logic [7:0]  sum_add;
  logic [7:0]  cur_byte;
  logic        adv;
  logic        emit;
  logic        last_data;
  logic [1:0]  sym_kind;
  logic [7:0]  sym_byte;
  logic        sym_last;
  logic        sym_status;

  assign adv       = ~out_valid | out_ready;
  assign cur_byte  = job.data[{idx, 3'b000} +: 8];
  assign last_data = ({1'b0, idx} + 4'd1) == job.len;

  // End-around-carry add
  assign sum_wide = {1'b0, sum} + {1'b0, cur_byte};
  assign sum_add  = sum_wide[7:0] + {7'd0, sum_wide[8]};

  // Next state
  always_comb begin
    state_next = state;
    if (emit) begin
      case (state)
        ST_IDLE: begin
          if (head.kind == JOB_HEADER || head.kind == JOB_FRAME) begin
            state_next = ST_SYNC;
          end
        end
        ST_SYNC: state_next = ST_PID;
        ST_PID:  state_next = (job.kind == JOB_FRAME) ? ST_DATA : ST_IDLE;
        ST_DATA: state_next = last_data ? ST_CSUM : ST_DATA;
        ST_CSUM: state_next = ST_IDLE;
        default: state_next = ST_IDLE;
      endcase
    end
  end

  // Symbol for this step
  always_comb begin
    emit       = adv;
    queue_pop  = 1'b0;
    sym_kind   = KIND_BYTE;
    sym_byte   = 8'd0;
    sym_last   = 1'b0;
    sym_status = job.status;
    case (state)
      ST_IDLE: begin
        emit       = adv & ~queue_empty;
        queue_pop  = emit;
        sym_status = head.status;
        case (head.kind)
          JOB_REJECT: begin
            sym_kind = KIND_REJECT;
            sym_last = 1'b1;
          end
          JOB_WAKE: begin
            sym_byte = WAKE_BYTE;
            sym_last = 1'b1;
          end
          default: sym_kind = KIND_BREAK;
        endcase
      end
      ST_SYNC: sym_byte = SYNC_BYTE;
      ST_PID: begin
        sym_byte = job.pid;
        sym_last = (job.kind == JOB_HEADER);
      end
      ST_DATA: sym_byte = cur_byte;
      ST_CSUM: begin
        sym_byte = ~sum;
        sym_last = 1'b1;
      end
      default: emit = 1'b0;
    endcase
  end

  // Sequencer control
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  // Job context and checksum
  always_ff @(posedge clk) begin
    if (queue_pop) begin
      job <= head;
    end
    if (emit && state == ST_PID) begin
      sum <= job.enhanced ? job.pid : 8'd0;
      idx <= '0;
    end else if (emit && state == ST_DATA) begin
      sum <= sum_add;
      idx <= idx + 1'b1;
    end
  end

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (emit) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (emit) begin
      out_kind   <= sym_kind;
      out_byte   <= sym_byte;
      out_last   <= sym_last;
      out_status <= sym_status;
    end
  end

endmodule

// ===== design/lin_master_frame_transmitter.sv =====
// The first symbol of a request passes through the job queue and the output
// register. One bus symbol per cycle unless m_axis_tready stalls; a request
// has 1 symbol for reject/wakeup, 3 for header only and up to 12 for a frame
// with response, set by the symbol sequencer. A 2-entry job queue decouples
// intake from the sequencer. Synchronous reset clears enable and status to 0.
// ----------------------------------------------------------------------------
// lin_master_frame_transmitter: LIN master frame transmitter
// Turns frame, go-to-sleep and wakeup requests into a stream of bus symbols.
// ----------------------------------------------------------------------------
module lin_master_frame_transmitter import lmft_pkg::*; (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_wr_en,
  input  logic        cfg_wr_data,    // driver_enabled
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // [5:0] frame_id, [6] enhanced_checksum, [7] master_response,
  // [11:8] data_length, [75:12] data_bytes, [79:76] zero
  input  logic [79:0] s_axis_tdata,
  input  logic [1:0]  s_axis_tuser,   // [1:0] cmd
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  output logic [15:0] m_axis_tdata,   // [7:0] byte_value, [8] status, [15:9] zero
  output logic [1:0]  m_axis_tuser,   // [1:0] symbol_kind
  output logic        m_axis_tlast    // last
);

  queue_ctl_t q_in;
  queue_ctl_t q_out;
  job_t       front_job;
  job_t       head_job;
  logic [7:0] out_byte;
  logic       out_status;

  // Intake
  lmft_front u_front (
    .clk               (clk),
    .rst               (rst),
    .cfg_wr_en         (cfg_wr_en),
    .cfg_wr_data       (cfg_wr_data),
    .req_valid         (s_axis_tvalid),
    .req_ready         (s_axis_tready),
    .cmd               (s_axis_tuser),
    .frame_id          (s_axis_tdata[5:0]),
    .enhanced_checksum (s_axis_tdata[6]),
    .master_response   (s_axis_tdata[7]),
    .data_length       (s_axis_tdata[11:8]),
    .data_bytes        (s_axis_tdata[75:12]),
    .queue_full        (q_out.full),
    .queue_push        (q_in.push),
    .job               (front_job)
  );

  assign q_in.full  = 1'b0;
  assign q_in.empty = 1'b0;

  // Job queue
  lmft_queue u_queue (
    .clk     (clk),
    .rst     (rst),
    .ctl_in  (q_in),
    .ctl_out (q_out),
    .wr_job  (front_job),
    .rd_job  (head_job)
  );

  // Symbol sequencer
  lmft_back u_back (
    .clk         (clk),
    .rst         (rst),
    .queue_empty (q_out.empty),
    .queue_pop   (q_in.pop),
    .head        (head_job),
    .out_valid   (m_axis_tvalid),
    .out_ready   (m_axis_tready),
    .out_kind    (m_axis_tuser),
    .out_byte    (out_byte),
    .out_last    (m_axis_tlast),
    .out_status  (out_status)
  );

  assign m_axis_tdata = {7'd0, out_status, out_byte};

`ifndef ASSERT_OFF
  // A reject is always a request's only symbol
  a_reject_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_REJECT) |-> m_axis_tlast)
    else $error("reject symbol without last");

  // A break field never ends a request
  a_break_not_last: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser == KIND_BREAK) |-> !m_axis_tlast)
    else $error("break symbol marked last");

  // Only byte symbols carry a nonzero byte
  a_nonbyte_zero: assert property (@(posedge clk) disable iff (rst)
    (m_axis_tvalid && m_axis_tuser != KIND_BYTE) |-> (m_axis_tdata[7:0] == 8'd0))
    else $error("nonzero byte on non-byte symbol");

  // Queue never reports full and empty together
  a_queue_sane: assert property (@(posedge clk) disable iff (rst)
    !(q_out.full && q_out.empty))
    else $error("queue full and empty at once");
`endif

endmodule
